// ----- src/b64d_pkg.sv -----
// Shared types, constants and the symbol classifier for the base64 decoder.
package b64d_pkg;

    localparam int unsigned B64D_QUEUE_DEPTH = 4;

    localparam logic [15:0] CODE_PLUS  = 16'd43;
    localparam logic [15:0] CODE_SLASH = 16'd47;
    localparam logic [15:0] CODE_0     = 16'd48;
    localparam logic [15:0] CODE_9     = 16'd57;
    localparam logic [15:0] CODE_UC_A  = 16'd65;
    localparam logic [15:0] CODE_UC_Z  = 16'd90;
    localparam logic [15:0] CODE_LC_A  = 16'd97;
    localparam logic [15:0] CODE_LC_Z  = 16'd122;

    // Decoded group handed from the front end to the byte emitter.
    typedef struct packed {
        logic [23:0] word;    // bytes to send, first byte in [23:16]
        logic [1:0]  nbytes;  // 1 to 3
    } group_t;

    // Bit 6 set marks noise; otherwise [5:0] is the sextet.
    function automatic logic [6:0] sextet_of(input logic [15:0] c);
        logic [15:0] d;
        d = 16'd0;
        if (c >= CODE_UC_A && c <= CODE_UC_Z) begin
            d = c - CODE_UC_A;
            return {1'b0, d[5:0]};
        end
        if (c >= CODE_LC_A && c <= CODE_LC_Z) begin
            d = c - CODE_LC_A + 16'd26;
            return {1'b0, d[5:0]};
        end
        if (c >= CODE_0 && c <= CODE_9) begin
            d = c - CODE_0 + 16'd52;
            return {1'b0, d[5:0]};
        end
        if (c == CODE_PLUS) begin
            return 7'd62;
        end
        if (c == CODE_SLASH) begin
            return 7'd63;
        end
        return 7'd64;
    endfunction

endpackage

// ----- src/b64d_front.sv -----
// Front end: classifies each symbol, collects sextets and forms byte groups.
module b64d_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sym_valid,
    output logic            sym_stall,
    input  logic [15:0]     in_symbol,
    input  logic            end_of_text,
    input  logic            q_full,
    output logic            q_push,
    output b64d_pkg::group_t q_data
);
    import b64d_pkg::*;

    logic [17:0] pend_reg;
    logic [17:0] pend_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [6:0]  sext;
    logic        accept;
    group_t      grp;

    assign sext      = sextet_of(in_symbol);
    assign sym_stall = q_full;
    assign accept    = sym_valid && !q_full;

    always_comb
    begin
        grp.word   = 24'd0;
        grp.nbytes = 2'd0;
        pend_next  = pend_reg;
        count_next = count_reg;
        if (!sext[6])
        begin
            if (count_reg == 2'd3)
            begin
                grp.word   = {pend_reg, sext[5:0]};
                grp.nbytes = 2'd3;
                pend_next  = 18'd0;
                count_next = 2'd0;
            end
            else
            begin
                pend_next  = {pend_reg[11:0], sext[5:0]};
                count_next = count_reg + 2'd1;
            end
        end
        if (end_of_text)
        begin
            // flush partial group, missing sextets as zero; a lone sextet is dropped
            case (count_next)
                2'd2:
                begin
                    grp.word   = {pend_next[11:0], 12'd0};
                    grp.nbytes = 2'd1;
                end
                2'd3:
                begin
                    grp.word   = {pend_next, 6'd0};
                    grp.nbytes = 2'd2;
                end
                default:
                begin
                end
            endcase
            pend_next  = 18'd0;
            count_next = 2'd0;
        end
    end

    assign q_push = accept && (grp.nbytes != 2'd0);
    assign q_data = grp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 18'd0;
            count_reg <= 2'd0;
        end
        else if (accept)
        begin
            pend_reg  <= pend_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/b64d_queue.sv -----
// Small group queue between the front end and the byte emitter.
module b64d_queue #(
    parameter int unsigned DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64d_pkg::group_t wr_data,
    output logic             full,
    input  logic             pop,
    output logic             rd_valid,
    output b64d_pkg::group_t rd_data
);
    import b64d_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    group_t          slots_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slots_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/b64d_back.sv -----
// Back end: unpacks queued groups into bytes, one transfer per cycle while byte_stall is low.
module b64d_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  b64d_pkg::group_t q_data,
    output logic             q_pop,
    output logic             byte_valid,
    input  logic             byte_stall,
    output logic [7:0]       out_byte,
    output logic             run_last
);
    import b64d_pkg::*;

    logic [23:0] word_reg;
    logic [1:0]  rem_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        advance;
    logic        load;

    // a byte moves into the output register when there is one and the slot frees up
    assign advance = (rem_reg != 2'd0) && (!valid_reg || !byte_stall);
    assign load    = q_valid && ((rem_reg == 2'd0) || (rem_reg == 2'd1 && advance));
    assign q_pop   = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                rem_reg <= q_data.nbytes;
            end
            else if (advance)
            begin
                rem_reg <= rem_reg - 2'd1;
            end
            if (advance)
            begin
                valid_reg <= 1'b1;
            end
            else if (!byte_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= q_data.word;
        end
        else if (advance)
        begin
            word_reg <= {word_reg[15:0], 8'd0};
        end
        if (advance)
        begin
            byte_reg <= word_reg[23:16];
            last_reg <= (rem_reg == 2'd1);
        end
    end

    assign byte_valid = valid_reg;
    assign out_byte   = byte_reg;
    assign run_last   = last_reg;

endmodule

// ----- src/base64_noise_skipping_decoder_unit.sv -----
// Top level of the noise-skipping base64 decoder.
// Takes one character code per cycle on the symbol channel while sym_stall is low;
// anything outside A-Z a-z 0-9 + / is skipped. Every fourth alphabet symbol yields
// three bytes, and end_of_text flushes a partial group as count-1 bytes (none for one).
// Bytes leave one transfer per cycle from a registered output while byte_stall is low;
// run_last marks the final byte caused by an input transfer. A symbol's first byte
// passes from the group queue through the emitter's word register into the output
// register; the emitter loads a group from the queue once it is done with the last one.
// Sustained input rate is one symbol per cycle while sym_stall is low; the emitter drains
// one byte per cycle while byte_stall is low, which keeps up since bytes never outnumber
// the symbols that cause them. sym_stall rises only when the group queue (QUEUE_DEPTH
// groups) is full because the output side is stalled.
module base64_noise_skipping_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sym_valid,
    output logic        sym_stall,
    input  logic [15:0] in_symbol,
    input  logic        end_of_text,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  out_byte,
    output logic        run_last
);
    import b64d_pkg::*;

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    group_t q_wr;
    group_t q_rd;

    b64d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sym_valid   (sym_valid),
        .sym_stall   (sym_stall),
        .in_symbol   (in_symbol),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wr)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_data  (q_wr),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd)
    );

    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_rd),
        .q_pop      (q_pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .run_last   (run_last)
    );

endmodule

// ----- src/b64d_checker.sv -----
// Port-level checks for the base64 decoder, bound to the top level.
module b64d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        sym_stall,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  out_byte,
    input logic        run_last
);

    // a stalled byte transfer keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(out_byte) && $stable(run_last))
        else $error("output payload changed while stalled");

    // bytes of one group follow back to back
    a_group_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && !run_last |=> byte_valid)
        else $error("gap inside a byte group");

    // no output right out of reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !byte_valid)
        else $error("output valid right after reset");

    // input is not stalled right out of reset
    a_no_early_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !sym_stall)
        else $error("input stalled right after reset");

endmodule

bind base64_noise_skipping_decoder_unit b64d_checker u_b64d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .sym_stall  (sym_stall),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .run_last   (run_last)
);
